/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the core, rcps_checker.sv.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, skipped while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/rcps_pkg.sv */
// Package for the row carve pixel selector: request and result types,
// row width constants and the wrap-around hue distance function. No dependencies.
package rcps_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int COL_W     = 12;
  localparam int HUE_W     = 15;
  localparam int LIGHT_W   = 16;
  localparam int DIST_W    = 14;
  localparam int SCORE_W   = 16;

  // One full turn of hue in 1/64 degree
  localparam logic [HUE_W-1:0] HUE_FULL_TURN = HUE_W'(360 * 64);

  localparam logic SEL_LIGHTNESS = 1'b0;
  localparam logic SEL_HUE_DIFF  = 1'b1;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [LIGHT_W-1:0] lightness;
    logic               last_in_row;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] selected_column;
    logic             short_row;
  } out_t;

  // Shorter of the two ways around the hue circle; never above half a turn
  function automatic logic [DIST_W-1:0] hue_distance(input logic [HUE_W-1:0] a,
                                                     input logic [HUE_W-1:0] b);
    logic [HUE_W-1:0] lo;
    logic [HUE_W-1:0] hi;
    logic [HUE_W-1:0] direct;
    logic [HUE_W-1:0] wrap;
    logic [HUE_W-1:0] shortest;
    lo       = (a < b) ? a : b;
    hi       = (a < b) ? b : a;
    direct   = hi - lo;
    wrap     = (HUE_FULL_TURN >= direct) ? (HUE_FULL_TURN - direct)
                                         : (direct - HUE_FULL_TURN);
    shortest = (direct < wrap) ? direct : wrap;
    return shortest[DIST_W-1:0];
  endfunction

endpackage

/* rtl/core/rcps_score.sv */
// Candidate score for the pixel one back: its lightness, or the sum of its
// hue distances to both neighbours. Depends on rcps_pkg.
module rcps_score
  import rcps_pkg::*;
(
  input  logic               mode,
  input  logic [HUE_W-1:0]   hue_two_back,
  input  logic [HUE_W-1:0]   hue_one_back,
  input  logic [HUE_W-1:0]   hue_now,
  input  logic [LIGHT_W-1:0] lightness_one_back,
  output logic [SCORE_W-1:0] score
);

  logic [DIST_W-1:0] dist_right;
  logic [DIST_W-1:0] dist_left;

  // Measure both neighbour distances in parallel
  assign dist_right = hue_distance(hue_one_back, hue_now);
  assign dist_left  = hue_distance(hue_one_back, hue_two_back);

  // Pick the score for the active mode
  always_comb begin
    if (mode == SEL_HUE_DIFF) begin
      score = SCORE_W'(dist_right) + SCORE_W'(dist_left);
    end else begin
      score = lightness_one_back;
    end
  end

endmodule

/* rtl/core/row_carve_pixel_selector.sv */
// Row carve pixel selector. A request enters the input register; its result (on a
// last_in_row pixel) goes to the output register and shows at out_valid. One pixel per
// cycle, set by the single scoring stage and running minimum, unless a row's last pixel
// waits on a full output. Reset (rst_n low, synchronous) clears the mode to lightness,
// empties both registers and clears the row state. Depends on rcps_pkg and rcps_score.
module row_carve_pixel_selector
  import rcps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_data
);

  logic               mode_r;
  logic               in_vld_r;
  in_t                in_r;
  logic               out_vld_r;
  logic               out_vld_nxt;
  out_t               out_r;
  out_t               out_nxt;

  logic [CNT_W-1:0]   cnt_r,        cnt_nxt;
  logic [HUE_W-1:0]   hue2_r,       hue2_nxt;
  logic [HUE_W-1:0]   hue1_r,       hue1_nxt;
  logic [LIGHT_W-1:0] light1_r,     light1_nxt;
  logic [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [COL_W-1:0]   best_col_r,   best_col_nxt;

  logic               stage_go;
  logic               in_row;
  logic               cand;
  logic               take;
  logic [SCORE_W-1:0] score;

  // Advance the stage unless a result has nowhere to go
  assign stage_go  = in_vld_r & (~in_r.last_in_row | ~out_vld_r | out_ready);
  assign in_ready  = ~in_vld_r | stage_go;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  rcps_score u_score (
    .mode               (mode_r),
    .hue_two_back       (hue2_r),
    .hue_one_back       (hue1_r),
    .hue_now            (in_r.hue),
    .lightness_one_back (light1_r),
    .score              (score)
  );

  // Score the pixel one back once its right neighbour is in the window
  assign in_row = (cnt_r < CNT_W'(MAX_WIDTH));
  assign cand   = in_row & (cnt_r >= CNT_W'(2));
  assign take   = cand & ((cnt_r == CNT_W'(2)) | (score < best_score_r));

  // Update the row window and running minimum
  always_comb begin
    cnt_nxt        = cnt_r;
    hue2_nxt       = hue2_r;
    hue1_nxt       = hue1_r;
    light1_nxt     = light1_r;
    best_score_nxt = best_score_r;
    best_col_nxt   = best_col_r;
    if (take) begin
      best_score_nxt = score;
      best_col_nxt   = COL_W'(cnt_r - CNT_W'(1));
    end
    if (in_row) begin
      hue2_nxt   = hue1_r;
      hue1_nxt   = in_r.hue;
      light1_nxt = in_r.lightness;
      cnt_nxt    = cnt_r + CNT_W'(1);
    end
  end

  // Build the result and manage the output register
  always_comb begin
    out_nxt.short_row       = (cnt_r < CNT_W'(2));
    out_nxt.selected_column = out_nxt.short_row ? '0 : best_col_nxt;
    out_vld_nxt             = out_vld_r & ~out_ready;
    if (stage_go && in_r.last_in_row) begin
      out_vld_nxt = 1'b1;
    end
  end

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= SEL_LIGHTNESS;
    end else if (cfg_we) begin
      mode_r <= cfg_data;
    end
  end

  // Capture requests into the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Advance row state; clear it when the row ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      hue2_r       <= '0;
      hue1_r       <= '0;
      light1_r     <= '0;
      best_score_r <= '0;
      best_col_r   <= '0;
    end else if (stage_go) begin
      if (in_r.last_in_row) begin
        cnt_r        <= '0;
        hue2_r       <= '0;
        hue1_r       <= '0;
        light1_r     <= '0;
        best_score_r <= '0;
        best_col_r   <= '0;
      end else begin
        cnt_r        <= cnt_nxt;
        hue2_r       <= hue2_nxt;
        hue1_r       <= hue1_nxt;
        light1_r     <= light1_nxt;
        best_score_r <= best_score_nxt;
        best_col_r   <= best_col_nxt;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && in_r.last_in_row) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* rtl/core/rcps_checker.sv */
// Port-level checks for row_carve_pixel_selector, attached by bind.
// Depends on rcps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcps_checker
  import rcps_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Drop any result while in reset
  `ASSERT_CLK_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  // Hold a stalled result
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // Report column zero for a short row
  `ASSERT_CLK(a_short_col, out_valid && out_data.short_row |-> out_data.selected_column == '0, "short row with nonzero column")

  // Never pick the first pixel of a full row
  `ASSERT_CLK(a_interior_col, out_valid && !out_data.short_row |-> out_data.selected_column != '0, "first column selected")

endmodule

bind row_carve_pixel_selector rcps_checker u_rcps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* bench/row_carve_pixel_selector_test.sv */
// Self-checking bench for the row carve pixel selector: drives pixel rows, predicts the
// carved column per row and checks every result. Depends on rcps_pkg and the selector RTL.
module row_carve_pixel_selector_test;
  import rcps_pkg::*;

  localparam int unsigned HUE_TURN       = 360 * 64;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  typedef enum int {STYLE_WIDE, STYLE_IN_RANGE, STYLE_TIES} pix_style_e;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we    = 1'b0;
  logic cfg_data  = 1'b0;

  // Stimulus and expectation stores
  in_t  pixel_q[$];
  out_t carve_expect_q[$];
  int unsigned items_queued = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;
  bit rx_hold_arm = 1'b0;
  bit in_took = 1'b0;

  // Predicted selector state
  bit          mode_now = SEL_LIGHTNESS;
  int unsigned row_cols = 0;
  int unsigned prev2_hue = 0;
  int unsigned prev1_hue = 0;
  int unsigned prev1_light = 0;
  int unsigned best_score = 0;
  int unsigned best_col = 0;

  row_carve_pixel_selector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shorter way around the hue circle; out-of-range hues use the same formula
  function automatic int unsigned hue_gap(int unsigned a, int unsigned b);
    int unsigned d;
    int unsigned w;
    d = (a > b) ? a - b : b - a;
    w = (d <= HUE_TURN) ? HUE_TURN - d : d - HUE_TURN;
    return (d < w) ? d : w;
  endfunction

  // Advance the row state by one pixel; push the carve column when the row ends
  task automatic predict_carve(input in_t px);
    int unsigned c;
    int unsigned s;
    out_t r;
    c = row_cols;
    if (c < MAX_WIDTH) begin
      if (c >= 2) begin
        if (mode_now == SEL_LIGHTNESS) begin
          s = prev1_light;
        end else begin
          s = hue_gap(prev1_hue, 32'(px.hue)) + hue_gap(prev1_hue, prev2_hue);
        end
        s = s & 32'hFFFF;
        if (c == 2 || s < best_score) begin
          best_score = s;
          best_col = c - 1;
        end
      end
      prev2_hue = prev1_hue;
      prev1_hue = 32'(px.hue);
      prev1_light = 32'(px.lightness);
      row_cols = c + 1;
    end
    if (px.last_in_row) begin
      r.short_row = (c < 2);
      r.selected_column = (c < 2) ? '0 : COL_W'(best_col);
      carve_expect_q.push_back(r);
      row_cols = 0;
      prev2_hue = 0;
      prev1_hue = 0;
      prev1_light = 0;
      best_score = 0;
      best_col = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
  endtask

  task automatic queue_pixel(input int unsigned hue, input int unsigned light, input bit last);
    in_t p;
    p.hue = HUE_W'(hue);
    p.lightness = LIGHT_W'(light);
    p.last_in_row = last;
    pixel_q.push_back(p);
    items_queued++;
  endtask

  task automatic queue_row(input int unsigned len, input pix_style_e style, input bit close);
    int unsigned h;
    int unsigned l;
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        STYLE_WIDE: begin
          h = $urandom;
          l = $urandom;
        end
        STYLE_IN_RANGE: begin
          h = $urandom_range(HUE_TURN - 1);
          l = $urandom_range(65535);
        end
        default: begin
          case ($urandom_range(3))
            0: h = 0;
            1: h = 64;
            2: h = HUE_TURN / 2;
            default: h = HUE_TURN - 1;
          endcase
          case ($urandom_range(2))
            0: l = 0;
            1: l = 1;
            default: l = 65535;
          endcase
        end
      endcase
      queue_pixel(h, l, close && (i == len - 1));
    end
  endtask

  // Fill the request queue with whole rows, sometimes leaving a row open at the end
  task automatic queue_random_rows(input int unsigned target, input bit short_only);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    start = items_queued;
    while (items_queued - start < target) begin
      pick = $urandom_range(99);
      if (short_only) len = $urandom_range(4, 3);
      else if (pick < 8) len = $urandom_range(2, 1);
      else if (pick < 80) len = $urandom_range(12, 3);
      else len = $urandom_range(60, 13);
      queue_row(len, pix_style_e'($urandom_range(2)), 1'b1);
    end
    if ($urandom_range(1) != 0)
      queue_row($urandom_range(4, 1), pix_style_e'($urandom_range(2)), 1'b0);
  endtask

  // Wait for all requests and results, then let any partial-row work finish
  task automatic drain_block();
    while (pixel_q.size() != 0 || in_valid || carve_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    mode_now = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present the next request once the previous one is taken; idle at random
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random and during a long hold-off
  always @(negedge clk) begin
    out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  // Count down the receiver hold-off
  always @(negedge clk) begin
    if (rx_hold_arm) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Check results against the oldest expectation, then predict from accepted requests
  always @(posedge clk) begin : monitor
    out_t want;
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (carve_expect_q.size() == 0) begin
          report_mismatch("result with none expected, column",
                          32'(out_data.selected_column), 0);
        end else begin
          want = carve_expect_q.pop_front();
          if (out_data.selected_column !== want.selected_column)
            report_mismatch("selected_column", 32'(out_data.selected_column),
                            32'(want.selected_column));
          if (out_data.short_row !== want.short_row)
            report_mismatch("short_row", 32'(out_data.short_row), 32'(want.short_row));
        end
      end
      if (in_valid && in_ready) predict_carve(in_data);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("row_carve_pixel_selector_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows in lightness mode: short rows, extremes and a tie
    write_mode(SEL_LIGHTNESS);
    queue_pixel(HUE_TURN - 1, 65535, 1'b1);
    queue_pixel(0, 0, 1'b0);
    queue_pixel(32767, 65535, 1'b1);
    queue_pixel(HUE_TURN - 1, 0, 1'b0);
    queue_pixel(0, 65535, 1'b0);
    queue_pixel(32767, 0, 1'b1);
    queue_pixel(100, 9, 1'b0);
    queue_pixel(200, 3, 1'b0);
    queue_pixel(300, 3, 1'b0);
    queue_pixel(400, 3, 1'b0);
    queue_pixel(500, 9, 1'b1);
    drain_block();

    // Directed rows in hue mode: wrap-around and out-of-range hues
    write_mode(SEL_HUE_DIFF);
    queue_pixel(0, 0, 1'b0);
    queue_pixel(HUE_TURN - 1, 0, 1'b0);
    queue_pixel(10, 65535, 1'b0);
    queue_pixel(HUE_TURN / 2, 0, 1'b0);
    queue_pixel(0, 0, 1'b1);
    queue_pixel(32767, 1, 1'b0);
    queue_pixel(0, 2, 1'b0);
    queue_pixel(32767, 3, 1'b0);
    queue_pixel(16000, 4, 1'b1);
    // Switch mode in the middle of a row
    queue_pixel(5000, 40000, 1'b0);
    queue_pixel(5100, 20000, 1'b0);
    queue_pixel(9000, 30000, 1'b0);
    drain_block();
    write_mode(SEL_LIGHTNESS);
    queue_pixel(9050, 10000, 1'b0);
    queue_pixel(20000, 50000, 1'b0);
    queue_pixel(0, 60000, 1'b1);
    drain_block();

    // No idling: random rows
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    queue_random_rows(300, 1'b0);
    drain_block();

    // Sender mostly idle
    write_mode(SEL_HUE_DIFF);
    tx_idle_pct = 84;
    queue_random_rows(300, 1'b0);
    drain_block();

    // Receiver mostly stalled
    write_mode(SEL_LIGHTNESS);
    tx_idle_pct = 0;
    rx_stall_pct = 84;
    queue_random_rows(300, 1'b0);
    drain_block();

    // Both sides idle a little; the sender pauses halfway until all results are in
    write_mode(SEL_HUE_DIFF);
    tx_idle_pct = 14;
    rx_stall_pct = 14;
    queue_random_rows(150, 1'b0);
    drain_block();
    queue_random_rows(150, 1'b0);
    drain_block();

    // Hold the receiver off while short rows keep coming, so the input backs up
    write_mode(1'($urandom_range(1)));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_arm = 1'b1;
    @(posedge clk);
    rx_hold_arm = 1'b0;
    queue_random_rows(200, 1'b1);
    drain_block();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("row_carve_pixel_selector_test OK");
    end else begin
      $display("row_carve_pixel_selector_test NOT OK");
    end
    $finish;
  end

endmodule
